/* rtl/core/priority_route_fact_table_assert.svh */
// assertion macros for the route fact table
`ifndef PRIORITY_ROUTE_FACT_TABLE_ASSERT_SVH
`define PRIORITY_ROUTE_FACT_TABLE_ASSERT_SVH
// implication checked on every clock edge out of reset
`define PRFT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define PRFT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

/* rtl/core/prft_pkg.sv */
package prft_pkg;
  localparam logic [1:0] ACT_ONLINE  = 2'd0;
  localparam logic [1:0] ACT_OFFLINE = 2'd1;
  localparam logic [1:0] ACT_EXPIRE  = 2'd2;
  localparam logic [1:0] ACT_LOOKUP  = 2'd3;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;

  // table geometry; counts and the hop field are sized for these
  localparam int SLOTS    = 32;
  localparam int HOP_BITS = 48;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  source;
    logic [63:0] device_key;
    logic [63:0] now_ms;
  } req_t;

  // data handed from cell to cell during a scan
  typedef struct packed {
    logic        match_hit;
    logic        free_hit;
    logic        best_hit;
    logic [2:0]  best_prio;
    logic [31:0] best_seq;
    logic        old_hit;
    logic [31:0] old_seq;
    logic [5:0]  online_cnt;
    logic [5:0]  exp_cnt;
  } scan_t;

  // source priority rank; ranks rise with the source code, so ordering by source code orders by rank
  function automatic logic [6:0] prio_of(input logic [2:0] s);
    logic [6:0] p;
    case (s)
      3'd1: p = 7'd10;
      3'd2: p = 7'd20;
      3'd3: p = 7'd30;
      3'd4: p = 7'd40;
      3'd5: p = 7'd50;
      3'd6: p = 7'd60;
      3'd7: p = 7'd70;
      default: p = 7'd0;
    endcase
    return p;
  endfunction
endpackage

/* rtl/core/prft_if.sv */
interface prft_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  source;
  logic [63:0] device_key;
  logic [47:0] hop_in;
  logic [63:0] seen_ms;
  logic [31:0] ttl_ms;
  logic [63:0] now_ms;
  modport source_mp (output valid, action, source, device_key, hop_in, seen_ms,
                     ttl_ms, now_ms, input ready);
  modport sink (input valid, action, source, device_key, hop_in, seen_ms,
                ttl_ms, now_ms, output ready);
endinterface

interface prft_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [47:0] hop_out;
  logic [5:0]  expired_count;
  logic [5:0]  online_count;
  modport source_mp (output valid, status, found, hop_out, expired_count, online_count,
                     input ready);
  modport sink (input valid, status, found, hop_out, expired_count, online_count,
                output ready);
endinterface

/* rtl/core/prft_cell.sv */
// one slot: holds its entry and updates the shared scan state when the scan visits it
module prft_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,       // scan visits this slot now
  input  prft_pkg::req_t                req,
  input  prft_pkg::scan_t               scan_in,
  input  logic                          wr_en,
  input  logic                          wr_new,
  input  logic [31:0]                   wr_seq,
  input  logic [prft_pkg::HOP_BITS-1:0] wr_hop,
  input  logic [63:0]                   wr_obs,
  input  logic [31:0]                   wr_ttl,
  input  logic                          clr_en,
  output prft_pkg::scan_t               scan_out,
  output logic                          is_match,
  output logic                          is_best,
  output logic                          is_old,
  output logic                          expire_me,
  output logic [prft_pkg::HOP_BITS-1:0] hop
);
  logic                          on_r;
  logic [2:0]                    src_r;
  logic [63:0]                   key_r;
  logic [prft_pkg::HOP_BITS-1:0] hop_r;
  logic [63:0]                   obs_r;
  logic [31:0]                   ttl_r;
  logic [31:0]                   seq_r;
  logic [63:0]                   age;
  logic                          keyeq;

  assign hop   = hop_r;
  assign age   = req.now_ms - obs_r;
  assign keyeq = on_r && key_r == req.device_key;
  assign is_match = keyeq && src_r == req.source;
  assign expire_me = on_r && ttl_r != '0 && obs_r != '0 && req.now_ms >= obs_r &&
                     age >= {32'd0, ttl_r};
  assign is_best = keyeq && (!scan_in.best_hit || src_r > scan_in.best_prio ||
                   (src_r == scan_in.best_prio && seq_r > scan_in.best_seq));
  assign is_old = on_r && (!scan_in.old_hit || seq_r < scan_in.old_seq);

  always_comb begin
    scan_out = scan_in;
    if (step) begin
      if (is_match) scan_out.match_hit = 1'b1;
      if (!on_r) scan_out.free_hit = 1'b1;
      if (on_r) scan_out.online_cnt = scan_in.online_cnt + 6'd1;
      if (is_best) begin
        scan_out.best_hit = 1'b1;
        scan_out.best_prio = src_r;
        scan_out.best_seq = seq_r;
      end
      if (is_old) begin
        scan_out.old_hit = 1'b1;
        scan_out.old_seq = seq_r;
      end
      if (req.action == prft_pkg::ACT_EXPIRE && expire_me)
        scan_out.exp_cnt = scan_in.exp_cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r <= 1'b0;
    end else if (clr_en) begin
      on_r <= 1'b0;
    end else if (wr_en) begin
      on_r <= 1'b1;
    end
    if (wr_en) begin
      hop_r <= wr_hop;
      obs_r <= wr_obs;
      ttl_r <= wr_ttl;
      if (wr_new) begin
        src_r <= req.source;
        key_r <= req.device_key;
        seq_r <= wr_seq;
      end
    end
  end
endmodule

/* rtl/core/priority_route_fact_table.sv */
// Route fact table with SLOTS entries held in a row of slot cells. Each beat is
// processed alone: a scan token walks the row one slot per cycle, carrying the
// running match, free-slot, best-priority, oldest-entry and count state from
// cell to cell, then the update state writes or clears the chosen slots and the
// result is registered and offered in the output state. The next beat is
// accepted only after the result is taken, so a result held by the receiver
// keeps the input stalled. Lookups rank by source code, which orders the same
// as the source priority table. Reset empties the table at once through
// per-slot online bits; fallback_enable is to be written through cfg_we /
// cfg_wdata only while idle, and the block itself does not enforce this.
module priority_route_fact_table (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  prft_in_if.sink       in_ch,
  prft_out_if.source_mp out_ch
);
  localparam int SLOTS    = prft_pkg::SLOTS;
  localparam int HOP_BITS = prft_pkg::HOP_BITS;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_UPD = 4'b0100, S_OUT = 4'b1000
  } state_t;

  state_t state_r;
  logic   fb_r;
  logic [IW-1:0] idx_r;
  prft_pkg::req_t req_r;
  logic [HOP_BITS-1:0] nhop_r;
  logic [63:0] obs_r;
  logic [31:0] ttl_r;
  logic [31:0] seq_cnt_r;
  prft_pkg::scan_t acc_r;
  logic [IW-1:0] mi_r, fi_r, bi_r, oi_r;  // slot indexes of match/free/best/oldest
  logic [HOP_BITS-1:0] cell_hop [SLOTS];
  logic [SLOTS-1:0] c_match, c_best, c_old, c_exp, c_wr, c_clr;
  prft_pkg::scan_t c_out [SLOTS];
  prft_pkg::scan_t step_out;
  logic [1:0]  st_r;
  logic        fnd_r;
  logic [47:0] hop_o_r;
  logic [5:0]  exp_o_r;
  logic [5:0]  cnt_o_r;
  logic        bad;
  logic        valid_req;

  assign in_ch.ready = state_r == S_IDLE;
  assign out_ch.valid = state_r == S_OUT;
  assign out_ch.status = st_r;
  assign out_ch.found = fnd_r;
  assign out_ch.hop_out = hop_o_r;
  assign out_ch.expired_count = exp_o_r;
  assign out_ch.online_count = cnt_o_r;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      prft_cell u_cell (
        .clk(clk), .rst_n(rst_n),
        .step(state_r == S_SCAN && idx_r == IW'(g)),
        .req(req_r), .scan_in(acc_r),
        .wr_en(c_wr[g]), .wr_new(!acc_r.match_hit), .wr_seq(seq_cnt_r),
        .wr_hop(nhop_r), .wr_obs(obs_r), .wr_ttl(ttl_r), .clr_en(c_clr[g]),
        .scan_out(c_out[g]), .is_match(c_match[g]), .is_best(c_best[g]),
        .is_old(c_old[g]), .expire_me(c_exp[g]), .hop(cell_hop[g])
      );
    end
  endgenerate

  assign step_out = c_out[idx_r];
  assign bad = req_r.source == '0 || req_r.device_key == '0;
  assign valid_req = !bad;

  // write and clear strobes for the update cycle
  always_comb begin
    c_wr = '0;
    c_clr = '0;
    if (state_r == S_UPD) begin
      unique case (req_r.action)
        prft_pkg::ACT_ONLINE: begin
          if (valid_req && acc_r.match_hit) c_wr[mi_r] = 1'b1;
          else if (valid_req && acc_r.free_hit) c_wr[fi_r] = 1'b1;
        end
        prft_pkg::ACT_OFFLINE: if (valid_req && acc_r.match_hit) c_clr[mi_r] = 1'b1;
        prft_pkg::ACT_EXPIRE: c_clr = c_exp;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fb_r <= 1'b0;
      seq_cnt_r <= 32'd1;
    end else begin
      if (cfg_we) fb_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: if (in_ch.valid) state_r <= S_SCAN;
        S_SCAN: if (idx_r == IW'(SLOTS - 1)) state_r <= S_UPD;
        S_UPD: begin
          state_r <= S_OUT;
          if (req_r.action == prft_pkg::ACT_ONLINE && valid_req && !acc_r.match_hit &&
              acc_r.free_hit)
            seq_cnt_r <= (seq_cnt_r == '1) ? 32'd1 : seq_cnt_r + 32'd1;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      req_r <= '{action: in_ch.action, source: in_ch.source,
                 device_key: in_ch.device_key, now_ms: in_ch.now_ms};
      nhop_r <= in_ch.hop_in[HOP_BITS-1:0];
      obs_r <= in_ch.seen_ms;
      ttl_r <= in_ch.ttl_ms;
      idx_r <= '0;
      acc_r <= '0;
    end else if (state_r == S_SCAN) begin
      acc_r <= step_out;
      if (c_match[idx_r] && !acc_r.match_hit) mi_r <= idx_r;
      if (!acc_r.free_hit && step_out.free_hit) fi_r <= idx_r;
      if (c_best[idx_r]) bi_r <= idx_r;
      if (c_old[idx_r]) oi_r <= idx_r;
      if (idx_r != IW'(SLOTS - 1)) idx_r <= idx_r + IW'(1);
    end else if (state_r == S_UPD) begin
      st_r <= prft_pkg::ST_OK;
      fnd_r <= 1'b0;
      hop_o_r <= '0;
      exp_o_r <= '0;
      cnt_o_r <= acc_r.online_cnt;
      unique case (req_r.action)
        prft_pkg::ACT_ONLINE: begin
          if (bad) st_r <= prft_pkg::ST_INVALID;
          else if (!acc_r.match_hit && !acc_r.free_hit) st_r <= prft_pkg::ST_NO_SPACE;
          else if (!acc_r.match_hit) cnt_o_r <= acc_r.online_cnt + 6'd1;
        end
        prft_pkg::ACT_OFFLINE: begin
          if (bad) st_r <= prft_pkg::ST_INVALID;
          else if (acc_r.match_hit) cnt_o_r <= acc_r.online_cnt - 6'd1;
        end
        prft_pkg::ACT_EXPIRE: begin
          exp_o_r <= acc_r.exp_cnt;
          cnt_o_r <= acc_r.online_cnt - acc_r.exp_cnt;
        end
        default: begin
          if (req_r.device_key == '0) begin
            st_r <= prft_pkg::ST_INVALID;
          end else if (acc_r.best_hit) begin
            fnd_r <= 1'b1;
            hop_o_r <= 48'(cell_hop[bi_r]);
          end else if (fb_r && acc_r.old_hit) begin
            fnd_r <= 1'b1;
            hop_o_r <= 48'(cell_hop[oi_r]);
          end
        end
      endcase
    end
  end
endmodule

/* rtl/core/prft_checker.sv */
// port-level checks on the route fact table
`include "priority_route_fact_table_assert.svh"
module prft_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        found,
  input logic [47:0] hop_out,
  input logic [5:0]  online_count
);
  `PRFT_ASSERT_IMP(a_excl, out_valid, !in_ready)
  `PRFT_ASSERT_IMP(a_hop_zero, out_valid && !found, hop_out == '0)
  `PRFT_ASSERT_IMP(a_status, out_valid, status != 2'd3)
  `PRFT_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(online_count))
endmodule

bind priority_route_fact_table prft_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .status(out_ch.status), .found(out_ch.found),
  .hop_out(out_ch.hop_out), .online_count(out_ch.online_count)
);
